FILE: hdl/pdrs_pkg.sv
// Shared types and constants for the pickup/delivery route splitter.
// Item structs for both channels, register indexes and distance format.
// No dependencies.
`timescale 1ns / 1ps

package pdrs_pkg;

   // Fraction bits of every distance value
   localparam int DIST_FRAC_BITS = 8;

   localparam int AMOUNT_W    = 16;
   localparam int DIST_W      = 24;
   localparam int ROUTE_W     = 32;
   localparam int SUM_W       = 40;
   localparam int COUNT_W     = 8;
   localparam int TOTAL_W     = 24;
   localparam int LOAD_W      = 18;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 1;

   localparam logic [CSR_DATA_W-1:0] START_LOAD_RESET   = 16'd180;
   localparam logic [CSR_DATA_W-1:0] MAX_CAPACITY_RESET = 16'd180;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_START_LOAD   = 1'b0,
      CSR_MAX_CAPACITY = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic                first_of_tour;
      logic                last_of_tour;
      logic [AMOUNT_W-1:0] delivery_amount;
      logic [AMOUNT_W-1:0] pickup_amount;
      logic [DIST_W-1:0]   dist_from_prev;
      logic [DIST_W-1:0]   dist_from_depot;
      logic [DIST_W-1:0]   dist_to_depot;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] route_index;
      logic [ROUTE_W-1:0] route_distance;
      logic [COUNT_W-1:0] route_stops;
      logic [TOTAL_W-1:0] tour_total;
      logic               tour_done;
   } rsp_type;

endpackage

FILE: hdl/pickup_delivery_route_split_core.sv
// Top level of the pickup/delivery route splitter.
// Uses pdrs_pkg for item types, register indexes and the distance format.
`timescale 1ns / 1ps

//  channel | ports                               | direction | moves
//  --------+-------------------------------------+-----------+----------------------------
//  req     | req_valid, req_ready, req_item      | in        | one customer item
//  rsp     | rsp_valid, rsp_ready, rsp_item      | out       | one closed route item
//  csr     | csr_we, csr_index, csr_wdata        | in        | register write, no wait
//
//  One customer item is taken per cycle. Its whole effect on the running state is
//  worked out in the accepting cycle and its zero, one or two route items land in a
//  four-entry result queue; rsp shows the oldest queued route item straight from the queue.
//  req_ready is high while at least two queue entries are free, so a stalled rsp side
//  holds the queue and, once full, holds req; otherwise nothing stalls.
//  Synchronous reset clears the tour state, empties the queue and loads both
//  registers with 180.

module pickup_delivery_route_split_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  pdrs_pkg::req_type                    req_item,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output pdrs_pkg::rsp_type                    rsp_item,
   input  logic                                 csr_we,
   input  logic [pdrs_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [pdrs_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int AW = pdrs_pkg::AMOUNT_W;
   localparam int DW = pdrs_pkg::DIST_W;
   localparam int RW = pdrs_pkg::ROUTE_W;
   localparam int SW = pdrs_pkg::SUM_W;
   localparam int CW = pdrs_pkg::COUNT_W;
   localparam int TW = pdrs_pkg::TOTAL_W;
   localparam int LW = pdrs_pkg::LOAD_W;
   // wide enough for any load or goods difference without wrap
   localparam int XW = LW + 2;
   localparam int QDEPTH = 4;
   localparam int QAW = 2;

   // ---------------------------------------------------------------- helpers
   function automatic logic [RW-1:0] sat_route(input logic [RW-1:0] a,
                                               input logic [RW-1:0] b);
      logic [RW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[RW] ? {RW{1'b1}} : s[RW-1:0];
   endfunction

   function automatic logic [SW-1:0] sat_sum(input logic [SW-1:0] a,
                                             input logic [RW-1:0] b);
      logic [SW:0] s;
      s = {1'b0, a} + {{(SW-RW+1){1'b0}}, b};
      return s[SW] ? {SW{1'b1}} : s[SW-1:0];
   endfunction

   function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] a);
      return (a == {CW{1'b1}}) ? a : a + {{(CW-1){1'b0}}, 1'b1};
   endfunction

   // ---------------------------------------------------------------- registers
   logic [AW-1:0]        start_load_ff, max_capacity_ff;
   logic signed [LW-1:0] goods_left_ff, goods_left_in;
   logic signed [LW-1:0] load_now_ff, load_now_in;
   logic [RW-1:0]        open_dist_ff, open_dist_in;
   logic [SW-1:0]        tour_sum_ff, tour_sum_in;
   logic [CW-1:0]        route_count_ff, route_count_in;
   logic [CW-1:0]        stop_count_ff, stop_count_in;
   logic [DW-1:0]        prev_back_ff, prev_back_in;

   pdrs_pkg::rsp_type    queue_ff [QDEPTH];
   logic [QAW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QAW:0]         count_ff, count_in;

   // ---------------------------------------------------------------- datapath
   logic                 accept, pop;
   logic                 new_tour, join_route, reject;
   logic signed [XW-1:0] goods_ext, load_ext, del_ext, pick_ext, start_ext, cap_ext;
   logic signed [XW-1:0] goods_try, load_try, goods_open, load_open;
   logic [RW-1:0]        dist_from_ext, dist_to_ext, prev_back_ext, dist_prev_ext;
   logic [RW-1:0]        rd_a, rd_b, dist_one;
   logic [SW-1:0]        tsum_a, tsum_one, tsum_b, tsum_shift;
   logic [CW-1:0]        routes_one, stops_one;
   logic signed [LW-1:0] goods_one, load_one;
   logic [TW-1:0]        total_b;
   logic                 push_a, push_b;
   pdrs_pkg::rsp_type    result_a, result_b, slot0, slot1;

   assign accept = req_valid && req_ready;
   assign pop    = rsp_valid && rsp_ready;

   assign goods_ext  = {{(XW-LW){goods_left_ff[LW-1]}}, goods_left_ff};
   assign load_ext   = {{(XW-LW){load_now_ff[LW-1]}}, load_now_ff};
   assign del_ext    = {{(XW-AW){1'b0}}, req_item.delivery_amount};
   assign pick_ext   = {{(XW-AW){1'b0}}, req_item.pickup_amount};
   assign start_ext  = {{(XW-AW){1'b0}}, start_load_ff};
   assign cap_ext    = {{(XW-AW){1'b0}}, max_capacity_ff};

   assign dist_from_ext = {{(RW-DW){1'b0}}, req_item.dist_from_depot};
   assign dist_to_ext   = {{(RW-DW){1'b0}}, req_item.dist_to_depot};
   assign dist_prev_ext = {{(RW-DW){1'b0}}, req_item.dist_from_prev};
   assign prev_back_ext = {{(RW-DW){1'b0}}, prev_back_ff};

   // A route count of zero means no tour is open: treat as a first customer.
   assign new_tour   = req_item.first_of_tour || (route_count_ff == '0);
   assign goods_try  = goods_ext - del_ext;
   assign load_try   = load_ext - del_ext + pick_ext;
   assign join_route = !new_tour && !goods_try[XW-1] && (load_try <= cap_ext);
   assign reject     = !new_tour && !join_route;

   assign goods_open = start_ext - del_ext;
   assign load_open  = start_ext - del_ext + pick_ext;

   // Close the open route through the depot when this customer does not fit.
   assign rd_a   = sat_route(open_dist_ff, prev_back_ext);
   assign tsum_a = sat_sum(tour_sum_ff, rd_a);

   always_comb begin
      if (join_route) begin
         goods_one  = goods_try[LW-1:0];
         load_one   = load_try[LW-1:0];
         dist_one   = sat_route(open_dist_ff, dist_prev_ext);
         stops_one  = sat_inc(stop_count_ff);
         routes_one = route_count_ff;
         tsum_one   = tour_sum_ff;
      end else begin
         // open a fresh route with this customer
         goods_one  = goods_open[LW-1:0];
         load_one   = load_open[LW-1:0];
         dist_one   = dist_from_ext;
         stops_one  = {{(CW-1){1'b0}}, 1'b1};
         routes_one = new_tour ? {{(CW-1){1'b0}}, 1'b1} : sat_inc(route_count_ff);
         tsum_one   = new_tour ? '0 : tsum_a;
      end
   end

   // Last customer closes whatever route is open and reports the tour total.
   assign rd_b       = sat_route(dist_one, dist_to_ext);
   assign tsum_b     = sat_sum(tsum_one, rd_b);
   assign tsum_shift = tsum_b >> pdrs_pkg::DIST_FRAC_BITS;
   assign total_b    = (|tsum_shift[SW-1:TW]) ? {TW{1'b1}} : tsum_shift[TW-1:0];

   always_comb begin
      result_a.route_index    = route_count_ff;
      result_a.route_distance = rd_a;
      result_a.route_stops    = stop_count_ff;
      result_a.tour_total     = '0;
      result_a.tour_done      = 1'b0;
      result_b.route_index    = routes_one;
      result_b.route_distance = rd_b;
      result_b.route_stops    = stops_one;
      result_b.tour_total     = total_b;
      result_b.tour_done      = 1'b1;
   end

   assign push_a = accept && reject;
   assign push_b = accept && req_item.last_of_tour;
   assign slot0  = push_a ? result_a : result_b;
   assign slot1  = result_b;

   // Next tour state: clear everything after the last customer.
   always_comb begin
      goods_left_in  = goods_left_ff;
      load_now_in    = load_now_ff;
      open_dist_in   = open_dist_ff;
      tour_sum_in    = tour_sum_ff;
      route_count_in = route_count_ff;
      stop_count_in  = stop_count_ff;
      prev_back_in   = prev_back_ff;
      if (accept) begin
         if (req_item.last_of_tour) begin
            goods_left_in  = '0;
            load_now_in    = '0;
            open_dist_in   = '0;
            tour_sum_in    = '0;
            route_count_in = '0;
            stop_count_in  = '0;
            prev_back_in   = '0;
         end else begin
            goods_left_in  = goods_one;
            load_now_in    = load_one;
            open_dist_in   = dist_one;
            tour_sum_in    = tsum_one;
            route_count_in = routes_one;
            stop_count_in  = stops_one;
            prev_back_in   = req_item.dist_to_depot;
         end
      end
   end

   // ---------------------------------------------------------------- result queue
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      if (push_a && push_b) begin
         wr_ptr_in = wr_ptr_ff + QAW'(2);
      end else if (push_a || push_b) begin
         wr_ptr_in = wr_ptr_ff + QAW'(1);
      end
      rd_ptr_in = pop ? rd_ptr_ff + QAW'(1) : rd_ptr_ff;
      count_in  = count_ff + {{QAW{1'b0}}, push_a} + {{QAW{1'b0}}, push_b}
                  - {{QAW{1'b0}}, pop};
   end

   assign req_ready = (count_ff <= (QAW+1)'(QDEPTH - 2));
   assign rsp_valid = (count_ff != '0);
   assign rsp_item  = queue_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push_a || push_b) begin
         queue_ff[wr_ptr_ff] <= slot0;
      end
      if (push_a && push_b) begin
         queue_ff[wr_ptr_ff + QAW'(1)] <= slot1;
      end
   end

   // ---------------------------------------------------------------- state
   always_ff @(posedge clock) begin
      if (reset) begin
         start_load_ff   <= pdrs_pkg::START_LOAD_RESET;
         max_capacity_ff <= pdrs_pkg::MAX_CAPACITY_RESET;
         goods_left_ff   <= '0;
         load_now_ff     <= '0;
         open_dist_ff    <= '0;
         tour_sum_ff     <= '0;
         route_count_ff  <= '0;
         stop_count_ff   <= '0;
         prev_back_ff    <= '0;
         wr_ptr_ff       <= '0;
         rd_ptr_ff       <= '0;
         count_ff        <= '0;
      end else begin
         if (csr_we) begin
            case (pdrs_pkg::csr_index_type'(csr_index))
               pdrs_pkg::CSR_START_LOAD:   start_load_ff   <= csr_wdata;
               pdrs_pkg::CSR_MAX_CAPACITY: max_capacity_ff <= csr_wdata;
               default: ;
            endcase
         end
         goods_left_ff  <= goods_left_in;
         load_now_ff    <= load_now_in;
         open_dist_ff   <= open_dist_in;
         tour_sum_ff    <= tour_sum_in;
         route_count_ff <= route_count_in;
         stop_count_ff  <= stop_count_in;
         prev_back_ff   <= prev_back_in;
         wr_ptr_ff      <= wr_ptr_in;
         rd_ptr_ff      <= rd_ptr_in;
         count_ff       <= count_in;
      end
   end

endmodule

FILE: dv/tb_pickup_delivery_route_split_core.sv
// Self-checking testbench for pickup_delivery_route_split_core: a directed table of customers,
// random tours across register settings and idle modes, and long tours that saturate.
// Depends on pdrs_pkg and the core; expected route items come from a predictor held here.
`timescale 1ns / 1ps

module tb_pickup_delivery_route_split_core;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 4;
   localparam int HOLD_CYCLES   = 150;
   localparam int SEGMENT_ITEMS = 90;

   // Register settings per segment; the last entry is replaced by a random pair
   localparam bit [15:0] LOAD_CHOICES [8] = '{16'd180, 16'd0, 16'd65535, 16'd0,
                                             16'd65535, 16'd100, 16'd400, 16'd0};
   localparam bit [15:0] CAP_CHOICES  [8] = '{16'd180, 16'd0, 16'd65535, 16'd65535,
                                             16'd0, 16'd300, 16'd150, 16'd0};
   // Idle modes: sender idle and receiver stall, in percent of cycles
   localparam int IDLE_SEND [4] = '{0, 80, 0, 17};
   localparam int IDLE_RECV [4] = '{0, 0, 80, 17};

   typedef struct {
      pdrs_pkg::req_type customer;
      bit                typed;
      pdrs_pkg::rsp_type want;
   } script_row;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   pdrs_pkg::req_type req_item = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   pdrs_pkg::rsp_type rsp_item;
   logic              csr_we = 1'b0;
   logic [pdrs_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [pdrs_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   // Predictor copy of the registers and the tour state
   bit [15:0] cfg_start_load;
   bit [15:0] cfg_max_capacity;
   int        goods_on_board;
   int        vehicle_load;
   bit [31:0] open_route_length;
   bit [39:0] tour_length;
   bit [7:0]  route_number;
   bit [7:0]  stops_served;
   bit [23:0] return_leg;

   pdrs_pkg::rsp_type step_routes[$];      // routes closed by the customer just taken
   pdrs_pkg::rsp_type typed_routes[$];     // hand-written expectation for the next customer
   pdrs_pkg::rsp_type expected_routes[$];  // routes still owed by the block

   int mismatch_count = 0;
   int cycle_count = 0;
   int req_idle_pct = 0;
   int rsp_stall_pct = 0;
   bit rsp_hold_request = 1'b0;

   pickup_delivery_route_split_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic void clear_tour();
      goods_on_board    = 0;
      vehicle_load      = 0;
      open_route_length = '0;
      tour_length       = '0;
      route_number      = '0;
      stops_served      = '0;
      return_leg        = '0;
   endfunction

   // Start a route at the configured load with this customer as its only stop
   function automatic void open_route(input int del, input int pick, input bit [23:0] out_leg);
      goods_on_board    = int'(cfg_start_load) - del;
      vehicle_load      = int'(cfg_start_load) - del + pick;
      open_route_length = {8'd0, out_leg};
      stops_served      = 8'd1;
   endfunction

   // Close the open route through the depot; both distance sums saturate
   function automatic void close_route(input bit [23:0] back_leg, input bit done);
      bit [32:0] length_sum;
      bit [40:0] tour_sum;
      bit [31:0] length;
      bit [39:0] whole_units;
      pdrs_pkg::rsp_type r;
      length_sum  = {1'b0, open_route_length} + {9'd0, back_leg};
      length      = length_sum[32] ? '1 : length_sum[31:0];
      tour_sum    = {1'b0, tour_length} + {9'd0, length};
      tour_length = tour_sum[40] ? '1 : tour_sum[39:0];
      whole_units = tour_length >> pdrs_pkg::DIST_FRAC_BITS;
      r.route_index    = route_number;
      r.route_distance = length;
      r.route_stops    = stops_served;
      r.tour_total     = !done ? '0 : (whole_units > 40'hFF_FFFF) ? '1 : whole_units[23:0];
      r.tour_done      = done;
      step_routes.push_back(r);
   endfunction

   function automatic void advance_tour(input pdrs_pkg::req_type c);
      int del;
      int pick;
      int goods_next;
      int load_next;
      bit [32:0] length_sum;
      del  = c.delivery_amount;
      pick = c.pickup_amount;
      step_routes.delete();
      if (c.first_of_tour || route_number == 0) begin
         // new tour, or a restart that drops the open one silently
         tour_length  = '0;
         route_number = 8'd1;
         open_route(del, pick, c.dist_from_depot);
      end else begin
         goods_next = goods_on_board - del;
         load_next  = vehicle_load - del + pick;
         if (goods_next >= 0 && load_next <= int'(cfg_max_capacity)) begin
            goods_on_board    = goods_next;
            vehicle_load      = load_next;
            length_sum        = {1'b0, open_route_length} + {9'd0, c.dist_from_prev};
            open_route_length = length_sum[32] ? '1 : length_sum[31:0];
            if (stops_served != 8'd255) stops_served++;
         end else begin
            close_route(return_leg, 1'b0);
            if (route_number != 8'd255) route_number++;
            open_route(del, pick, c.dist_from_depot);
         end
      end
      return_leg = c.dist_to_depot;
      if (c.last_of_tour) begin
         close_route(c.dist_to_depot, 1'b1);
         clear_tour();
      end
   endfunction

   // ---------------------------------------------------------------- helpers

   function automatic pdrs_pkg::req_type cust(input bit first, input bit last,
                                              input bit [15:0] del, input bit [15:0] pick,
                                              input bit [23:0] prev,
                                              input bit [23:0] from_depot,
                                              input bit [23:0] to_depot);
      pdrs_pkg::req_type c;
      c.first_of_tour   = first;
      c.last_of_tour    = last;
      c.delivery_amount = del;
      c.pickup_amount   = pick;
      c.dist_from_prev  = prev;
      c.dist_from_depot = from_depot;
      c.dist_to_depot   = to_depot;
      return c;
   endfunction

   function automatic pdrs_pkg::rsp_type route(input bit [7:0] index, input bit [31:0] length,
                                               input bit [7:0] stops, input bit [23:0] total,
                                               input bit done);
      pdrs_pkg::rsp_type r;
      r.route_index    = index;
      r.route_distance = length;
      r.route_stops    = stops;
      r.tour_total     = total;
      r.tour_done      = done;
      return r;
   endfunction

   // Idle cycles before the next customer: each cycle idles with the set chance
   function automatic int pick_gap();
      int gap;
      gap = 0;
      while ($urandom_range(99) < req_idle_pct) gap++;
      return gap;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      $display("route check %s: got %0h, want %0h at %0t ns", what, got, want, $realtime);
   endtask

   // Offer one customer, hold it until accepted, then predict its routes.
   // Lower valid only when a gap is wanted, so valid never drops and rises in one step.
   task automatic send_customer(input pdrs_pkg::req_type c, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= c;
      do @(posedge clock); while (!req_ready);
      advance_tour(c);
      if (typed_routes.size() != 0) begin
         foreach (typed_routes[i]) expected_routes.push_back(typed_routes[i]);
         typed_routes.delete();
      end else begin
         foreach (step_routes[i]) expected_routes.push_back(step_routes[i]);
      end
   endtask

   // Stop offering, wait for every owed route, then let the block settle
   task automatic drain_routes();
      req_valid <= 1'b0;
      while (expected_routes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_settings(input bit [15:0] start_load, input bit [15:0] max_capacity);
      csr_we    <= 1'b1;
      csr_index <= pdrs_pkg::CSR_START_LOAD;
      csr_wdata <= start_load;
      @(posedge clock);
      cfg_start_load = start_load;
      csr_index <= pdrs_pkg::CSR_MAX_CAPACITY;
      csr_wdata <= max_capacity;
      @(posedge clock);
      cfg_max_capacity = max_capacity;
      csr_we <= 1'b0;
   endtask

   // Amounts scaled to the current settings so both accepts and rejects occur
   function automatic pdrs_pkg::req_type random_customer();
      pdrs_pkg::req_type c;
      int scale;
      scale = ((cfg_start_load > cfg_max_capacity) ? cfg_start_load : cfg_max_capacity) / 3 + 4;
      c.first_of_tour   = 1'b0;
      c.last_of_tour    = 1'b0;
      c.delivery_amount = ($urandom_range(9) == 0) ? $urandom_range(0, 65535)
                                                   : $urandom_range(0, scale);
      c.pickup_amount   = ($urandom_range(9) == 0) ? $urandom_range(0, 65535)
                                                   : $urandom_range(0, scale);
      c.dist_from_prev  = ($urandom_range(3) == 0) ? $urandom_range(0, 24'hFF_FFFF)
                                                   : $urandom_range(0, 24'h00_FFFF);
      c.dist_from_depot = ($urandom_range(3) == 0) ? $urandom_range(0, 24'hFF_FFFF)
                                                   : $urandom_range(0, 24'h00_FFFF);
      c.dist_to_depot   = ($urandom_range(3) == 0) ? $urandom_range(0, 24'hFF_FFFF)
                                                   : $urandom_range(0, 24'h00_FFFF);
      return c;
   endfunction

   // Mostly well-formed tours; now and then drop or misplace the tour marks
   task automatic send_random_tours(input int n_items);
      int sent;
      int len;
      pdrs_pkg::req_type c;
      sent = 0;
      while (sent < n_items) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
         for (int k = 0; k < len; k++) begin
            c = random_customer();
            c.first_of_tour = (k == 0);
            c.last_of_tour  = (k == len - 1);
            if ($urandom_range(19) == 0) c.first_of_tour = $urandom_range(1);
            if ($urandom_range(19) == 0) c.last_of_tour = $urandom_range(1);
            send_customer(c, pick_gap());
            sent++;
         end
      end
   endtask

   // ---------------------------------------------------------------- receiver side

   // Stall at random; on request hold off for a long stretch so the block backs up
   initial begin : rsp_side
      forever begin
         @(posedge clock);
         if (rsp_hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold_request = 1'b0;
         end
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Compare each accepted route item with the oldest one owed
   always @(posedge clock) begin : route_checker
      pdrs_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_routes.size() == 0) begin
            report_mismatch("unexpected route, index", rsp_item.route_index, '0);
         end else begin
            want = expected_routes.pop_front();
            if (rsp_item.route_index !== want.route_index)
               report_mismatch("route_index", rsp_item.route_index, want.route_index);
            if (rsp_item.route_distance !== want.route_distance)
               report_mismatch("route_distance", rsp_item.route_distance, want.route_distance);
            if (rsp_item.route_stops !== want.route_stops)
               report_mismatch("route_stops", rsp_item.route_stops, want.route_stops);
            if (rsp_item.tour_total !== want.tour_total)
               report_mismatch("tour_total", rsp_item.tour_total, want.tour_total);
            if (rsp_item.tour_done !== want.tour_done)
               report_mismatch("tour_done", rsp_item.tour_done, want.tour_done);
         end
      end
   end

   // Hard stop if the run hangs
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("end of test: mismatches");
      $finish;
   end

   // ---------------------------------------------------------------- stimulus

   initial begin : stimulus
      script_row script[$];
      int        pick;
      cfg_start_load   = pdrs_pkg::START_LOAD_RESET;
      cfg_max_capacity = pdrs_pkg::MAX_CAPACITY_RESET;
      clear_tour();

      // Directed customers; typed rows rely on reset settings of 180 / 180
      // single customer tour straight after reset
      script.push_back('{cust(1, 1, 16'd10, 16'd5, 24'd0, 24'h000100, 24'h000200), 1'b1,
                         route(8'd1, 32'h300, 8'd1, 24'd3, 1'b1)});
      // no tour open: taken as a first customer
      script.push_back('{cust(0, 1, 16'd0, 16'd0, 24'd7, 24'h000180, 24'h000080), 1'b1,
                         route(8'd1, 32'h200, 8'd1, 24'd2, 1'b1)});
      // every field at its top
      script.push_back('{cust(1, 1, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF),
                         1'b1, route(8'd1, 32'h1FF_FFFE, 8'd1, 24'h01_FFFF, 1'b1)});
      // every field at its bottom
      script.push_back('{cust(1, 1, 16'd0, 16'd0, 24'd0, 24'd0, 24'd0), 1'b1,
                         route(8'd1, 32'd0, 8'd1, 24'd0, 1'b1)});
      // a tour with accepts, a capacity reject, a goods reject and a negative load
      script.push_back('{cust(1, 0, 16'd60, 16'd20, 24'd0, 24'h001000, 24'h000800), 1'b0, '0});
      script.push_back('{cust(0, 0, 16'd50, 16'd30, 24'h000300, 24'h002000, 24'h000900),
                         1'b0, '0});
      script.push_back('{cust(0, 0, 16'd10, 16'd100, 24'h000400, 24'h003000, 24'h000A00),
                         1'b0, '0});
      script.push_back('{cust(0, 0, 16'd200, 16'd0, 24'h000500, 24'h004000, 24'h000B00),
                         1'b0, '0});
      script.push_back('{cust(0, 0, 16'd0, 16'd0, 24'h000600, 24'h005000, 24'h000C00),
                         1'b0, '0});
      // restart mid-tour, then a last customer that is rejected
      script.push_back('{cust(1, 0, 16'd5, 16'd0, 24'h000010, 24'h000020, 24'h000030),
                         1'b0, '0});
      script.push_back('{cust(0, 0, 16'd5, 16'd0, 24'h000011, 24'h000021, 24'h000031),
                         1'b0, '0});
      script.push_back('{cust(0, 1, 16'd500, 16'd0, 24'h000012, 24'h000022, 24'h000032),
                         1'b0, '0});
      // a last customer that joins the open route
      script.push_back('{cust(1, 0, 16'd0, 16'd0, 24'h000013, 24'h000023, 24'h000033),
                         1'b0, '0});
      script.push_back('{cust(0, 1, 16'd0, 16'd0, 24'h000014, 24'h000024, 24'h000034),
                         1'b0, '0});
      // single customer tour that restarts an open one
      script.push_back('{cust(1, 0, 16'd1, 16'd1, 24'h000015, 24'h000025, 24'h000035),
                         1'b0, '0});
      script.push_back('{cust(1, 1, 16'd2, 16'd2, 24'h000016, 24'h000026, 24'h000036),
                         1'b0, '0});

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].typed) typed_routes.push_back(script[i].want);
         send_customer(script[i].customer, 0);
      end

      // Random tours: four idle modes, two register settings in each
      for (int phase = 0; phase < 4; phase++) begin
         req_idle_pct  = IDLE_SEND[phase];
         rsp_stall_pct = IDLE_RECV[phase];
         for (int seg = 0; seg < 2; seg++) begin
            pick = phase * 2 + seg;
            drain_routes();
            if (pick == 7)
               write_settings($urandom_range(0, 65535), $urandom_range(0, 65535));
            else
               write_settings(LOAD_CHOICES[pick], CAP_CHOICES[pick]);
            // back the block up while the sender keeps offering
            if (pick == 0) rsp_hold_request = 1'b1;
            send_random_tours(SEGMENT_ITEMS);
         end
      end

      // Long route: distance sum and stop count saturate
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      drain_routes();
      write_settings(16'd0, 16'hFFFF);
      send_customer(cust(1, 0, 16'd0, 16'd0, 24'd0, 24'h000010, 24'h000020), 0);
      for (int k = 0; k < 298; k++)
         send_customer(cust(0, 0, 16'd0, 16'd0, 24'hFFFFFF, 24'h000010, 24'h000020), 0);
      send_customer(cust(0, 1, 16'd0, 16'd0, 24'hFFFFFF, 24'h000010, 24'hFFFFFF), 0);

      // Long tour of one-stop routes: route count and tour total saturate
      drain_routes();
      write_settings(16'd0, 16'd0);
      send_customer(cust(1, 0, 16'd0, 16'd1, 24'd0, 24'hFFFFFF, 24'hFFFFFF), 0);
      for (int k = 0; k < 300; k++)
         send_customer(cust(0, 0, 16'd0, 16'd1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF), 0);
      send_customer(cust(0, 1, 16'd0, 16'd1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF), 0);

      drain_routes();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
